### rtl/core/cba_pkg.sv
`timescale 1ns / 1ps
package cba_pkg;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_BAD  = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_FREE  = 1'b1;

   localparam logic [4:0] SPACES_AVAIL_RESET = 5'd16;

   typedef struct packed {
      logic load;
      logic div_step;
      logic sp_first;
      logic sp_next;
      logic sp_from_q;
      logic rd;
      logic scan_init;
      logic scan_step;
      logic wr_alloc;
      logic act_wr;
      logic free_wr;
      logic set_bad;
      logic set_full;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic bad_alloc;
      logic s_active;
      logic s_last;
      logic found;
      logic b_last;
      logic can_act;
      logic free_bad;
   } sts_type;

endpackage

### rtl/core/cba_dp.sv
`timescale 1ns / 1ps
module cba_dp #(
   parameter int NUM_SPACES   = 16,
   parameter int SPACE_BLOCKS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  cba_pkg::cmd_type cmd,
   output cba_pkg::sts_type sts,
   input  logic             req_action,
   input  logic [7:0]       req_owner_tag,
   input  logic [6:0]       req_block_count,
   input  logic [9:0]       req_block_location,
   input  logic             csr_write,
   input  logic [4:0]       csr_spaces_available,
   output logic [1:0]       rsp_status,
   output logic [9:0]       rsp_run_location,
   output logic             rsp_space_released
);

   localparam int SW   = $clog2(NUM_SPACES);
   localparam int BW   = $clog2(SPACE_BLOCKS);
   localparam int RW   = BW + 1;
   localparam int CMPW = (RW > 7) ? RW : 7;
   localparam int XW   = SW + 11;
   localparam int PW   = SW + BW + 10;
   localparam logic [CMPW:0] BPS_C = (CMPW + 1)'(SPACE_BLOCKS);
   // reciprocal of the space size, exact for any 10-bit location
   localparam int KSH   = 10 + BW;
   localparam int RECIP = ((1 << KSH) + SPACE_BLOCKS - 1) / SPACE_BLOCKS;
   localparam logic [11:0] RECIP_C = 12'(RECIP);

   logic [SPACE_BLOCKS-1:0] mem [NUM_SPACES];
   logic [SPACE_BLOCKS-1:0] rd_ff;
   logic                    rdv_ff;
   logic [NUM_SPACES-1:0]   valid_ff;
   logic [NUM_SPACES-1:0]   active_ff;
   logic [4:0]              csr_ff;

   logic        action_ff;
   logic [7:0]  tag_ff;
   logic [6:0]  count_ff;
   logic [9:0]  dv_ff;
   logic [9:0]  q_ff;
   logic [RW:0] rem_ff;
   logic [SW-1:0] s_ff;
   logic [BW-1:0] b_ff;
   logic [RW-1:0] run_ff;

   logic [1:0] res_status_ff;
   logic [9:0] res_loc_ff;
   logic       res_rel_ff;
   logic [1:0] rsp_status_ff;
   logic [9:0] rsp_loc_ff;
   logic       rsp_rel_ff;

   logic [SPACE_BLOCKS-1:0] row;
   logic [SPACE_BLOCKS-1:0] alloc_mask;
   logic [SPACE_BLOCKS-1:0] act_mask;
   logic [SPACE_BLOCKS-1:0] free_mask;
   logic [SPACE_BLOCKS-1:0] freed_row;
   logic [SPACE_BLOCKS-1:0] wr_data;
   logic        wr_en;
   logic [CMPW:0] cnt_x;
   logic [CMPW:0] run_next;
   logic [CMPW:0] first_x;
   logic [CMPW:0] b_x;
   logic [CMPW:0] start_x;
   logic [BW-1:0] start;
   logic [21:0]   loc_prod;
   logic [9:0]    q_calc;
   logic [19:0]   q_base;
   logic [9:0]    rem_calc;
   logic [SW-1:0] qs;
   logic          q_ok;
   logic [PW-1:0] alloc_loc;
   logic [PW-1:0] base_loc;
   logic          empty;

   assign row     = rdv_ff ? rd_ff : '0;
   assign cnt_x   = (CMPW + 1)'(count_ff);
   assign run_next = (CMPW + 1)'(run_ff) + (CMPW + 1)'(1);
   assign first_x = (CMPW + 1)'(rem_ff);
   assign b_x     = (CMPW + 1)'(b_ff);
   assign start   = b_ff - run_ff[BW-1:0];
   assign start_x = (CMPW + 1)'(start);
   assign qs      = q_ff[SW-1:0];
   assign q_ok    = XW'(q_ff) < XW'(NUM_SPACES);

   // space index by reciprocal multiply, block offset from the remainder
   assign loc_prod = 22'(req_block_location) * 22'(RECIP_C);
   assign q_calc   = 10'(loc_prod >> KSH);
   assign q_base   = 20'(q_ff) * 20'(SPACE_BLOCKS);
   assign rem_calc = dv_ff - q_base[9:0];

   always_comb begin
      for (int i = 0; i < SPACE_BLOCKS; i++) begin
         alloc_mask[i] = ((CMPW + 1)'(i) >= start_x) && ((CMPW + 1)'(i) <= b_x);
         act_mask[i]   = (CMPW + 1)'(i) < cnt_x;
         free_mask[i]  = ((CMPW + 1)'(i) >= first_x) && ((CMPW + 1)'(i) < first_x + cnt_x);
      end
   end

   assign freed_row = row & ~free_mask;
   assign empty     = freed_row == '0;
   assign alloc_loc = PW'(s_ff) * PW'(SPACE_BLOCKS) + PW'(start);
   assign base_loc  = PW'(s_ff) * PW'(SPACE_BLOCKS);

   assign wr_en = cmd.wr_alloc | cmd.act_wr | cmd.free_wr;
   always_comb begin
      priority if (cmd.wr_alloc) begin
         wr_data = row | alloc_mask;
      end else if (cmd.act_wr) begin
         wr_data = act_mask;
      end else begin
         wr_data = freed_row;
      end
   end

   assign sts.is_free   = action_ff == cba_pkg::ACTION_FREE;
   assign sts.bad_alloc = count_ff == 7'd0 || cnt_x > BPS_C || tag_ff == 8'd0;
   assign sts.s_active  = active_ff[s_ff];
   assign sts.s_last    = s_ff == SW'(NUM_SPACES - 1);
   assign sts.found     = !row[b_ff] && run_next >= cnt_x;
   assign sts.b_last    = b_ff == BW'(SPACE_BLOCKS - 1);
   assign sts.can_act   = !active_ff[s_ff] && (XW'(s_ff) < XW'(csr_ff));
   assign sts.free_bad  = count_ff == 7'd0 || !q_ok || !active_ff[qs] ||
                          (first_x + cnt_x > BPS_C);

   // occupancy map, one row per space
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[s_ff] <= wr_data;
      end
      if (cmd.rd) begin
         rd_ff  <= mem[s_ff];
         rdv_ff <= valid_ff[s_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         active_ff <= NUM_SPACES'(1);
         csr_ff    <= cba_pkg::SPACES_AVAIL_RESET;
      end else begin
         if (csr_write) begin
            csr_ff <= csr_spaces_available;
         end
         if (wr_en) begin
            valid_ff[s_ff] <= 1'b1;
         end
         if (cmd.act_wr) begin
            active_ff[s_ff] <= 1'b1;
         end
         if (cmd.free_wr && empty) begin
            active_ff[s_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         tag_ff    <= req_owner_tag;
         count_ff  <= req_block_count;
         dv_ff     <= req_block_location;
         q_ff      <= q_calc;
         rem_ff    <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= (RW + 1)'(rem_calc);
      end
      priority if (cmd.sp_first) begin
         s_ff <= '0;
      end else if (cmd.sp_next) begin
         s_ff <= s_ff + SW'(1);
      end else if (cmd.sp_from_q) begin
         s_ff <= qs;
      end
      priority if (cmd.scan_init) begin
         b_ff   <= '0;
         run_ff <= '0;
      end else if (cmd.scan_step) begin
         b_ff   <= b_ff + BW'(1);
         run_ff <= row[b_ff] ? '0 : run_ff + RW'(1);
      end
      priority if (cmd.wr_alloc) begin
         res_status_ff <= cba_pkg::STATUS_OK;
         res_loc_ff    <= alloc_loc[9:0];
         res_rel_ff    <= 1'b0;
      end else if (cmd.act_wr) begin
         res_status_ff <= cba_pkg::STATUS_OK;
         res_loc_ff    <= base_loc[9:0];
         res_rel_ff    <= 1'b0;
      end else if (cmd.free_wr) begin
         res_status_ff <= cba_pkg::STATUS_OK;
         res_loc_ff    <= '0;
         res_rel_ff    <= empty;
      end else if (cmd.set_bad) begin
         res_status_ff <= cba_pkg::STATUS_BAD;
         res_loc_ff    <= '0;
         res_rel_ff    <= 1'b0;
      end else if (cmd.set_full) begin
         res_status_ff <= cba_pkg::STATUS_FULL;
         res_loc_ff    <= '0;
         res_rel_ff    <= 1'b0;
      end
      if (cmd.publish) begin
         rsp_status_ff <= res_status_ff;
         rsp_loc_ff    <= res_loc_ff;
         rsp_rel_ff    <= res_rel_ff;
      end
   end

   assign rsp_status         = rsp_status_ff;
   assign rsp_run_location   = rsp_loc_ff;
   assign rsp_space_released = rsp_rel_ff;

`ifndef NO_ASSERTIONS
   a_alloc_active: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_alloc |-> active_ff[s_ff])
      else $error("alloc into inactive space");
   a_act_sets: assert property (@(posedge clock) disable iff (reset)
      cmd.act_wr |=> active_ff[$past(s_ff)] && valid_ff[$past(s_ff)])
      else $error("activation did not mark space");
   a_free_active: assert property (@(posedge clock) disable iff (reset)
      cmd.free_wr |-> active_ff[s_ff])
      else $error("free into inactive space");
`endif

endmodule

### rtl/core/cba_ctrl.sv
`timescale 1ns / 1ps
module cba_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  cba_pkg::sts_type sts,
   output cba_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      IDLE, CHECK, A_SEL, A_WAIT, SCAN, A_WR, ACT,
      DIV, F_CHK, F_RD, F_WAIT, F_WR, RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      out_free;

   assign req_ready = state_ff == IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CHECK;
            end
         end
         CHECK: begin
            priority if (sts.is_free) begin
               state_in = DIV;
            end else if (sts.bad_alloc) begin
               cmd.set_bad = 1'b1;
               state_in    = RESP;
            end else begin
               cmd.sp_first = 1'b1;
               state_in     = A_SEL;
            end
         end
         A_SEL: begin
            priority if (sts.s_active) begin
               cmd.rd        = 1'b1;
               cmd.scan_init = 1'b1;
               state_in      = A_WAIT;
            end else if (sts.s_last) begin
               cmd.sp_first = 1'b1;
               state_in     = ACT;
            end else begin
               cmd.sp_next = 1'b1;
            end
         end
         A_WAIT: state_in = SCAN;
         SCAN: begin
            priority if (sts.found) begin
               state_in = A_WR;
            end else if (sts.b_last && sts.s_last) begin
               cmd.sp_first = 1'b1;
               state_in     = ACT;
            end else if (sts.b_last) begin
               cmd.sp_next = 1'b1;
               state_in    = A_SEL;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         A_WR: begin
            cmd.wr_alloc = 1'b1;
            state_in     = RESP;
         end
         // lowest inactive space below the limit
         ACT: begin
            priority if (sts.can_act) begin
               cmd.act_wr = 1'b1;
               state_in   = RESP;
            end else if (sts.s_last) begin
               cmd.set_full = 1'b1;
               state_in     = RESP;
            end else begin
               cmd.sp_next = 1'b1;
            end
         end
         DIV: begin
            cmd.div_step = 1'b1;
            state_in     = F_CHK;
         end
         F_CHK: begin
            if (sts.free_bad) begin
               cmd.set_bad = 1'b1;
               state_in    = RESP;
            end else begin
               cmd.sp_from_q = 1'b1;
               state_in      = F_RD;
            end
         end
         F_RD: begin
            cmd.rd   = 1'b1;
            state_in = F_WAIT;
         end
         F_WAIT: state_in = F_WR;
         F_WR: begin
            cmd.free_wr = 1'b1;
            state_in    = RESP;
         end
         RESP: begin
            if (out_free) begin
               cmd.publish = 1'b1;
               state_in    = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while busy");
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == RESP))
      else $error("result shown outside response step");
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> !rsp_valid_ff || rsp_ready)
      else $error("result overwritten");
`endif

endmodule

### rtl/core/contiguous_block_allocator_top.sv
`timescale 1ns / 1ps
// free: reciprocal location divide, range check, one map read and one write back
// alloc: active spaces scanned in order from space 0, one block tested per cycle, then the
// lowest inactive space below the limit is activated; full if neither finds room
// one word in flight; the next word is taken while a result waits at the output
// reset is synchronous; map rows read as free until first written, no clearing pass
module contiguous_block_allocator_top #(
   parameter int NUM_SPACES   = 16,
   parameter int SPACE_BLOCKS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   input  logic [7:0] req_owner_tag,
   input  logic [6:0] req_block_count,
   input  logic [9:0] req_block_location,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [9:0] rsp_run_location,
   output logic       rsp_space_released,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [4:0] csr_spaces_available
);

   cba_pkg::cmd_type cmd;
   cba_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   cba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cba_dp #(
      .NUM_SPACES   (NUM_SPACES),
      .SPACE_BLOCKS (SPACE_BLOCKS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_action           (req_action),
      .req_owner_tag        (req_owner_tag),
      .req_block_count      (req_block_count),
      .req_block_location   (req_block_location),
      .csr_write            (csr_valid & csr_ready),
      .csr_spaces_available (csr_spaces_available),
      .rsp_status           (rsp_status),
      .rsp_run_location     (rsp_run_location),
      .rsp_space_released   (rsp_space_released)
   );

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
module testbench;

   localparam int NS  = 16;
   localparam int BPS = 64;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic       action;
      logic [7:0] tag;
      logic [6:0] count;
      logic [9:0] loc;
   } req_word_type;

   typedef struct {
      logic [1:0] status;
      logic [9:0] loc;
      logic       rel;
   } rsp_word_type;

   typedef struct {
      logic [9:0] loc;
      logic [6:0] count;
   } run_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_action = cba_pkg::ACTION_ALLOC;
   logic [7:0] req_owner_tag = 8'd0;
   logic [6:0] req_block_count = 7'd0;
   logic [9:0] req_block_location = 10'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [9:0] rsp_run_location;
   logic       rsp_space_released;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [4:0] csr_spaces_available = 5'd0;

   // predictor state
   logic [7:0] tag_map [NS*BPS];
   logic       space_on [NS];
   logic [4:0] space_limit;

   req_word_type req_backlog[$];
   rsp_word_type due_results[$];
   run_type      live_runs[$];

   int         mismatches = 0;
   int         send_idle = 27;
   int         recv_idle = 51;
   int         stall_left = 0;
   int         quiet_cycles = 0;
   bit         req_taken = 0;

   contiguous_block_allocator_top #(.NUM_SPACES(NS), .SPACE_BLOCKS(BPS)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_owner_tag(req_owner_tag), .req_block_count(req_block_count),
      .req_block_location(req_block_location),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_run_location(rsp_run_location), .rsp_space_released(rsp_space_released),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_spaces_available(csr_spaces_available)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void clear_allocator();
      for (int i = 0; i < NS*BPS; i++) tag_map[i] = 8'd0;
      for (int s = 0; s < NS; s++) space_on[s] = (s == 0);
      space_limit = cba_pkg::SPACES_AVAIL_RESET;
   endfunction

   function automatic rsp_word_type predict_allocation(req_word_type w);
      rsp_word_type r;
      int run, start, base, lim, first;
      bit done, empty;
      r.status = cba_pkg::STATUS_OK;
      r.loc = 10'd0;
      r.rel = 1'b0;
      done = 0;
      if (w.action == cba_pkg::ACTION_ALLOC) begin
         if (w.count == 0 || w.count > BPS || w.tag == 0) begin
            r.status = cba_pkg::STATUS_BAD;
         end else begin
            for (int s = 0; s < NS; s++) begin
               if (!done && space_on[s]) begin
                  base = s * BPS;
                  run = 0;
                  for (int b = 0; b < BPS; b++) begin
                     if (!done) begin
                        if (tag_map[base + b] == 8'd0) begin
                           run++;
                           if (run >= w.count) begin
                              start = b + 1 - run;
                              for (int k = start; k <= b; k++) tag_map[base + k] = w.tag;
                              r.loc = 10'(base + start);
                              done = 1;
                           end
                        end else begin
                           run = 0;
                        end
                     end
                  end
               end
            end
            lim = (space_limit > NS) ? NS : space_limit;
            for (int s = 0; s < lim; s++) begin
               if (!done && !space_on[s]) begin
                  base = s * BPS;
                  space_on[s] = 1'b1;
                  for (int b = 0; b < BPS; b++) tag_map[base + b] = (b < w.count) ? w.tag : 8'd0;
                  r.loc = 10'(base);
                  done = 1;
               end
            end
            if (!done) r.status = cba_pkg::STATUS_FULL;
            else live_runs.push_back('{r.loc, w.count});
         end
      end else begin
         base = (w.loc / BPS) * BPS;
         first = w.loc % BPS;
         if (w.count == 0 || (w.loc / BPS) >= NS || !space_on[w.loc / BPS] ||
             first + w.count > BPS) begin
            r.status = cba_pkg::STATUS_BAD;
         end else begin
            for (int b = first; b < first + w.count; b++) tag_map[base + b] = 8'd0;
            empty = 1;
            for (int b = 0; b < BPS; b++) if (tag_map[base + b] != 8'd0) empty = 0;
            if (empty) space_on[w.loc / BPS] = 1'b0;
            r.rel = empty;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t %s: got %0d expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // request driver
   always @(negedge clock) begin
      req_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the word until it is taken
      end else if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle) begin
         w = req_backlog.pop_front();
         req_action <= w.action;
         req_owner_tag <= w.tag;
         req_block_count <= w.count;
         req_block_location <= w.loc;
         req_valid <= 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
      req_taken = 0;
   end

   // result receiver
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      rsp_word_type want;
      req_word_type w;
      bit moved;
      moved = 0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            space_limit = csr_spaces_available;
            moved = 1;
         end
         if (req_valid && req_ready) begin
            w.action = req_action;
            w.tag = req_owner_tag;
            w.count = req_block_count;
            w.loc = req_block_location;
            due_results.push_back(predict_allocation(w));
            req_taken = 1;
            moved = 1;
         end
         if (rsp_valid && rsp_ready) begin
            moved = 1;
            if (due_results.size() == 0) begin
               report_mismatch("unexpected word status", rsp_status, -1);
            end else begin
               want = due_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_run_location !== want.loc)
                  report_mismatch("run_location", rsp_run_location, want.loc);
               if (rsp_space_released !== want.rel)
                  report_mismatch("space_released", rsp_space_released, want.rel);
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("contiguous_block_allocator_top: mismatch");
            $finish;
         end
      end
   end

   function automatic req_word_type make_word(logic act, int tag, int count, int loc);
      req_word_type w;
      w.action = act;
      w.tag = 8'(tag);
      w.count = 7'(count);
      w.loc = 10'(loc);
      return w;
   endfunction

   task automatic fill_batch(int n);
      int pick, idx;
      run_type rr;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick >= 55 && pick < 85 && live_runs.size() > 0) begin
            idx = $urandom_range(live_runs.size() - 1);
            rr = live_runs[idx];
            live_runs.delete(idx);
            if ($urandom_range(3) == 0)
               req_backlog.push_back(make_word(cba_pkg::ACTION_FREE, $urandom,
                                               $urandom_range(rr.count, 1), rr.loc));
            else
               req_backlog.push_back(make_word(cba_pkg::ACTION_FREE, $urandom, rr.count,
                                               rr.loc));
         end else if (pick >= 85 && pick < 92) begin
            req_backlog.push_back(make_word(1'($urandom), $urandom, $urandom, $urandom));
         end else if (pick >= 92) begin
            case ($urandom_range(3))
               0: req_backlog.push_back(make_word(cba_pkg::ACTION_ALLOC, $urandom_range(255, 1),
                                                  0, $urandom));
               1: req_backlog.push_back(make_word(cba_pkg::ACTION_ALLOC, $urandom_range(255, 1),
                                                  $urandom_range(127, 65), $urandom));
               2: req_backlog.push_back(make_word(cba_pkg::ACTION_ALLOC, 0,
                                                  $urandom_range(64, 1), $urandom));
               default: req_backlog.push_back(make_word(cba_pkg::ACTION_FREE, $urandom,
                                                        $urandom_range(64, 2),
                                                        $urandom_range(15) * BPS + 63));
            endcase
         end else begin
            req_backlog.push_back(make_word(cba_pkg::ACTION_ALLOC, $urandom_range(255, 1),
               ($urandom_range(4) == 0) ? $urandom_range(64, 1) : $urandom_range(12, 1),
               $urandom));
         end
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (req_backlog.size() != 0 || req_valid || due_results.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_limit(int value);
      @(negedge clock);
      csr_spaces_available <= 5'(value);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   int limits [7] = '{16, 2, 0, 31, 1, 16, 7};

   initial begin
      clear_allocator();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed words
      req_backlog.push_back(make_word(cba_pkg::ACTION_ALLOC, 5, 0, 0));
      req_backlog.push_back(make_word(cba_pkg::ACTION_ALLOC, 5, 65, 0));
      req_backlog.push_back(make_word(cba_pkg::ACTION_ALLOC, 5, 127, 1023));
      req_backlog.push_back(make_word(cba_pkg::ACTION_ALLOC, 0, 4, 0));
      req_backlog.push_back(make_word(cba_pkg::ACTION_ALLOC, 255, 64, 0));
      req_backlog.push_back(make_word(cba_pkg::ACTION_ALLOC, 1, 1, 0));
      req_backlog.push_back(make_word(cba_pkg::ACTION_FREE, 0, 0, 0));
      req_backlog.push_back(make_word(cba_pkg::ACTION_FREE, 0, 1, 1023));
      req_backlog.push_back(make_word(cba_pkg::ACTION_FREE, 0, 10, 60));
      req_backlog.push_back(make_word(cba_pkg::ACTION_FREE, 0, 64, 0));
      req_backlog.push_back(make_word(cba_pkg::ACTION_FREE, 0, 1, 64));
      req_backlog.push_back(make_word(cba_pkg::ACTION_FREE, 0, 1, 64));
      req_backlog.push_back(make_word(cba_pkg::ACTION_ALLOC, 170, 3, 0));
      req_backlog.push_back(make_word(cba_pkg::ACTION_ALLOC, 85, 61, 0));
      req_backlog.push_back(make_word(cba_pkg::ACTION_FREE, 255, 2, 1));
      req_backlog.push_back(make_word(cba_pkg::ACTION_ALLOC, 9, 2, 0));
      req_backlog.push_back(make_word(cba_pkg::ACTION_FREE, 0, 64, 0));
      req_backlog.push_back(make_word(cba_pkg::ACTION_FREE, 0, 127, 0));
      wait_idle();

      for (int p = 0; p < 7; p++) begin
         live_runs.delete();
         write_limit(limits[p]);
         send_idle = (p < 2) ? 27 : (p < 4) ? 51 : 0;
         recv_idle = (p < 2) ? 51 : (p < 4) ? 27 : 0;
         if (p == 1) begin
            // receiver holds off while words keep coming
            fill_batch(12);
            stall_left = 400;
            wait_idle();
         end
         for (int k = 0; k < 13; k++) begin
            fill_batch(8);
            do @(posedge clock); while (req_backlog.size() != 0);
         end
         wait_idle();
      end
      write_limit(0);
      req_backlog.push_back(make_word(cba_pkg::ACTION_ALLOC, 7, 64, 0));
      req_backlog.push_back(make_word(cba_pkg::ACTION_ALLOC, 7, 64, 0));
      wait_idle();
      repeat (100) @(posedge clock);
      if (mismatches == 0)
         $display("contiguous_block_allocator_top: match");
      else
         $display("contiguous_block_allocator_top: mismatch");
      $finish;
   end

endmodule

### filelist.f
rtl/core/cba_pkg.sv
rtl/core/cba_dp.sv
rtl/core/cba_ctrl.sv
rtl/core/contiguous_block_allocator_top.sv
bench/testbench.sv
